### design/xmcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmcs_pkg
// Shared types and constants of the XMODEM checksum block sender.
// ----------------------------------------------------------------------------
package xmcs_pkg;

  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] SYM_SOH = 8'h01;
  localparam logic [7:0] SYM_EOT = 8'h04;
  localparam logic [7:0] SYM_ACK = 8'h06;
  localparam logic [7:0] SYM_PAD = 8'h1A;

  typedef enum logic [1:0] {
    MODE_RX   = 2'd0,
    MODE_DATA = 2'd1,
    MODE_EOF  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE_ACK = 2'd1,
    ST_DONE_NAK = 2'd2,
    ST_DROP     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_WAIT_GO    = 2'd0,
    PH_IN_BLOCK   = 2'd1,
    PH_WAIT_REPLY = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CMD_GO       = 3'd0,
    CMD_GO_EOF   = 3'd1,
    CMD_FINISH   = 3'd2,
    CMD_DATA     = 3'd3,
    CMD_DATA_END = 3'd4,
    CMD_STATUS   = 3'd5
  } cmd_kind_e;

  // one classified item, expanded into results by the back end
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;    // block number or payload byte
    logic [7:0] pad;     // padding run length
    logic [7:0] sum;     // checksum to send
    status_e    status;
  } cmd_t;

endpackage

### design/xmcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmcs_queue
// Small register queue of commands between the front and back end.
// ----------------------------------------------------------------------------
module xmcs_queue #(
  parameter int unsigned Depth = xmcs_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xmcs_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output xmcs_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xmcs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

### design/xmcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmcs_front
// Accepts input transfers, tracks the transfer state and classifies each item
// into one command for the back end.
// ----------------------------------------------------------------------------
module xmcs_front #(
  parameter int unsigned BlockBytes = xmcs_pkg::BLOCK_BYTES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     in_mode_i,
  input  logic [7:0]     in_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output xmcs_pkg::cmd_t push_cmd_o
);

  localparam int unsigned CntW = $clog2(BlockBytes + 1);
  localparam logic [7:0] FullPadSum = 8'((BlockBytes * 26) % 256);

  xmcs_pkg::phase_e phase_q, phase_d;
  logic [7:0]       block_num_q, block_num_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic             eof_pend_q, eof_pend_d;

  logic            accept;
  xmcs_pkg::mode_e mode;
  logic [CntW-1:0] count_inc;
  logic [CntW-1:0] pad_cnt;
  logic [7:0]      pad_w;
  logic [7:0]      sum_fin;
  logic [7:0]      sum_inc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign mode       = xmcs_pkg::mode_e'(in_mode_i);
  assign count_inc  = count_q + 1'b1;
  assign pad_cnt    = CntW'(BlockBytes) - count_q;
  assign pad_w      = 8'(pad_cnt);
  assign sum_fin    = 8'(sum_q + 8'(pad_w * xmcs_pkg::SYM_PAD));
  assign sum_inc    = sum_q + in_byte_i;

  always_comb begin
    phase_d    = phase_q;
    block_num_d = block_num_q;
    count_d    = count_q;
    sum_d      = sum_q;
    eof_pend_d = eof_pend_q;

    push_cmd_o.kind   = xmcs_pkg::CMD_STATUS;
    push_cmd_o.data   = in_byte_i;
    push_cmd_o.pad    = pad_w;
    push_cmd_o.sum    = sum_fin;
    push_cmd_o.status = xmcs_pkg::ST_DROP;

    case (phase_q)
      xmcs_pkg::PH_IN_BLOCK: begin
        case (mode)
          xmcs_pkg::MODE_DATA: begin
            push_cmd_o.sum = sum_inc;
            if (count_inc == CntW'(BlockBytes)) begin
              push_cmd_o.kind = xmcs_pkg::CMD_DATA_END;
              block_num_d     = block_num_q + 1'b1;
              count_d         = '0;
              sum_d           = '0;
              phase_d         = xmcs_pkg::PH_WAIT_GO;
            end else begin
              push_cmd_o.kind = xmcs_pkg::CMD_DATA;
              count_d         = count_inc;
              sum_d           = sum_inc;
            end
          end
          xmcs_pkg::MODE_EOF: begin
            push_cmd_o.kind = xmcs_pkg::CMD_FINISH;
            sum_d           = sum_fin;
            count_d         = '0;
            phase_d         = xmcs_pkg::PH_WAIT_REPLY;
          end
          default: ;
        endcase
      end
      xmcs_pkg::PH_WAIT_REPLY: begin
        if (mode == xmcs_pkg::MODE_RX) begin
          push_cmd_o.status = (in_byte_i == xmcs_pkg::SYM_ACK) ?
                              xmcs_pkg::ST_DONE_ACK : xmcs_pkg::ST_DONE_NAK;
          phase_d     = xmcs_pkg::PH_WAIT_GO;
          block_num_d = 8'd1;
          count_d     = '0;
          sum_d       = '0;
          eof_pend_d  = 1'b0;
        end
      end
      default: begin
        // waiting for the go byte; unused phase code lands here too
        if (mode == xmcs_pkg::MODE_RX) begin
          push_cmd_o.data = block_num_q;
          count_d         = '0;
          if (eof_pend_q) begin
            push_cmd_o.kind = xmcs_pkg::CMD_GO_EOF;
            push_cmd_o.pad  = 8'(BlockBytes);
            push_cmd_o.sum  = FullPadSum;
            sum_d           = FullPadSum;
            eof_pend_d      = 1'b0;
            phase_d         = xmcs_pkg::PH_WAIT_REPLY;
          end else begin
            push_cmd_o.kind = xmcs_pkg::CMD_GO;
            sum_d           = '0;
            phase_d         = xmcs_pkg::PH_IN_BLOCK;
          end
        end else if (mode == xmcs_pkg::MODE_EOF && !eof_pend_q) begin
          push_cmd_o.status = xmcs_pkg::ST_BUSY;
          eof_pend_d        = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= xmcs_pkg::PH_WAIT_GO;
      block_num_q <= 8'd1;
      count_q     <= '0;
      sum_q       <= '0;
      eof_pend_q  <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      block_num_q <= block_num_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      eof_pend_q  <= eof_pend_d;
    end
  end

`ifndef SYNTHESIS
  a_eof_between_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_pend_q |-> (phase_q == xmcs_pkg::PH_WAIT_GO))
    else $error("eof pending outside of block gap");

  a_count_outside_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != xmcs_pkg::PH_IN_BLOCK) |-> (count_q == '0))
    else $error("byte count nonzero outside of block");

  a_count_below_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CntW'(BlockBytes))
    else $error("byte count reached block size");
`endif

endmodule

### design/xmcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmcs_back
// Expands queued commands into result transfers, one per cycle while the output
// side is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module xmcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  xmcs_pkg::cmd_t q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_tx_byte_o,
  output logic [7:0]     out_repeat_o,
  output logic [1:0]     out_status_o,
  output logic           out_last_o
);

  logic [2:0] step_q, step_d;
  logic       valid_q;
  logic [7:0] tx_q, rep_q;
  logic [1:0] st_q;
  logic       last_q;

  logic       load;
  logic [2:0] seq_idx;
  logic [7:0] res_tx, res_rep;
  logic [1:0] res_st;
  logic       res_last;

  assign load = q_valid_i && (!valid_q || out_ready_i);

  // header, padding and trailer share one sequence; finish starts at the pad
  assign seq_idx = (q_head_i.kind == xmcs_pkg::CMD_FINISH) ? step_q + 3'd3 : step_q;

  always_comb begin
    res_tx   = '0;
    res_rep  = 8'd1;
    res_st   = xmcs_pkg::ST_BUSY;
    res_last = 1'b0;
    case (q_head_i.kind)
      xmcs_pkg::CMD_GO, xmcs_pkg::CMD_GO_EOF, xmcs_pkg::CMD_FINISH: begin
        case (seq_idx)
          3'd0: res_tx = xmcs_pkg::SYM_SOH;
          3'd1: res_tx = q_head_i.data;
          3'd2: begin
            res_tx   = ~q_head_i.data;
            res_last = (q_head_i.kind == xmcs_pkg::CMD_GO);
          end
          3'd3: begin
            res_tx  = xmcs_pkg::SYM_PAD;
            res_rep = q_head_i.pad;
          end
          3'd4: res_tx = q_head_i.sum;
          default: begin
            res_tx   = xmcs_pkg::SYM_EOT;
            res_last = 1'b1;
          end
        endcase
      end
      xmcs_pkg::CMD_DATA: begin
        res_tx   = q_head_i.data;
        res_last = 1'b1;
      end
      xmcs_pkg::CMD_DATA_END: begin
        if (step_q == 3'd0) begin
          res_tx = q_head_i.data;
        end else begin
          res_tx   = q_head_i.sum;
          res_last = 1'b1;
        end
      end
      default: begin
        res_rep  = '0;
        res_st   = q_head_i.status;
        res_last = 1'b1;
      end
    endcase
  end

  assign pop_o = load && res_last;

  always_comb begin
    step_d = step_q;
    if (load) begin
      step_d = res_last ? 3'd0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_q   <= res_tx;
      rep_q  <= res_rep;
      st_q   <= res_st;
      last_q <= res_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_tx_byte_o = tx_q;
  assign out_repeat_o  = rep_q;
  assign out_status_o  = st_q;
  assign out_last_o    = last_q;

`ifndef SYNTHESIS
  a_mid_command_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 3'd0) |-> q_valid_i)
    else $error("sequencer mid-command with empty queue");

  a_status_only_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rep_q == 8'd0) |-> last_q)
    else $error("status-only result not marked last");

  a_status_has_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && st_q != xmcs_pkg::ST_BUSY) |-> (rep_q == 8'd0))
    else $error("terminal status carries a byte");
`endif

endmodule

### design/xmodem_checksum_block_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmodem_checksum_block_sender
// XMODEM sender framer with 8-bit additive checksum: front end classifier,
// command queue and result sequencer.
// ----------------------------------------------------------------------------
// An input transfer is accepted in any cycle in which the command queue has room, so
// payload bytes pass at one per cycle. Each input item yields one to six result
// transfers, issued by the back-end sequencer at one per cycle while the result side
// is ready, through a registered output stage: a payload byte gives one, the last
// byte of a block two (byte and checksum), a go byte three (SOH, number, complement),
// end of file inside a block three (padding run, checksum, EOT), and a go byte after
// an end of file between blocks six. End of file between blocks, the reply to EOT and
// every dropped item give one status-only result. The sequencer's one-result-per-cycle
// output with a ready result side sets the sustained rate; the queue lets the front
// keep accepting while a multi-result item drains.
module xmodem_checksum_block_sender #(
  parameter int unsigned BlockBytes = xmcs_pkg::BLOCK_BYTES,
  parameter int unsigned QueueDepth = xmcs_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] repeat_res, [17:16] status
  output logic        m_axis_tlast
);

  logic           push, q_full, q_valid, pop;
  xmcs_pkg::cmd_t push_cmd, q_head;
  logic [7:0]     tx_byte, repeat_res;
  logic [1:0]     status;

  xmcs_front #(
    .BlockBytes(BlockBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  xmcs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  xmcs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_tx_byte_o (tx_byte),
    .out_repeat_o  (repeat_res),
    .out_status_o  (status),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, status, repeat_res, tx_byte};

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the XMODEM checksum block sender. A scoreboard class
// predicts the framed byte runs and status results of every accepted item and
// checks each result transfer in order; both sides idle at random, and the
// result side holds off for long stretches so the block fills and stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_COUNT  = 450;

  typedef struct {
    logic [7:0]        tx_byte;
    logic [7:0]        reps;
    xmcs_pkg::status_e status;
    logic              last;
  } tx_result_t;

  class frame_scoreboard;
    xmcs_pkg::phase_e phase;
    logic [7:0]       block_num;
    logic [7:0]       fill;
    logic [7:0]       sum;
    bit               eof_pending;
    tx_result_t       tx_expected[$];
    int               errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase       = xmcs_pkg::PH_WAIT_GO;
      block_num   = 8'd1;
      fill        = 8'd0;
      sum         = 8'd0;
      eof_pending = 1'b0;
    endfunction

    function void push(logic [7:0] b, logic [7:0] r, xmcs_pkg::status_e s);
      tx_result_t t;
      t.tx_byte = b;
      t.reps    = r;
      t.status  = s;
      t.last    = 1'b0;
      tx_expected.push_back(t);
    endfunction

    // padding run for the rest of the block, then checksum and EOT
    function void pad_and_close();
      logic [7:0] pad;
      pad = 8'(xmcs_pkg::BLOCK_BYTES - fill);
      sum = sum + pad * xmcs_pkg::SYM_PAD;
      push(xmcs_pkg::SYM_PAD, pad, xmcs_pkg::ST_BUSY);
      push(sum, 8'd1, xmcs_pkg::ST_BUSY);
      push(xmcs_pkg::SYM_EOT, 8'd1, xmcs_pkg::ST_BUSY);
      phase = xmcs_pkg::PH_WAIT_REPLY;
      fill  = 8'd0;
    endfunction

    function void note_item(logic [1:0] mode, logic [7:0] b);
      if (phase == xmcs_pkg::PH_WAIT_GO && mode == xmcs_pkg::MODE_RX) begin
        push(xmcs_pkg::SYM_SOH, 8'd1, xmcs_pkg::ST_BUSY);
        push(block_num, 8'd1, xmcs_pkg::ST_BUSY);
        push(~block_num, 8'd1, xmcs_pkg::ST_BUSY);
        phase = xmcs_pkg::PH_IN_BLOCK;
        fill  = 8'd0;
        sum   = 8'd0;
        if (eof_pending) begin
          eof_pending = 1'b0;
          pad_and_close();
        end
      end else if (phase == xmcs_pkg::PH_WAIT_GO && mode == xmcs_pkg::MODE_EOF &&
                   !eof_pending) begin
        eof_pending = 1'b1;
        push(8'd0, 8'd0, xmcs_pkg::ST_BUSY);
      end else if (phase == xmcs_pkg::PH_IN_BLOCK && mode == xmcs_pkg::MODE_DATA) begin
        push(b, 8'd1, xmcs_pkg::ST_BUSY);
        sum  = sum + b;
        fill = fill + 8'd1;
        if (fill >= xmcs_pkg::BLOCK_BYTES) begin
          push(sum, 8'd1, xmcs_pkg::ST_BUSY);
          block_num = block_num + 8'd1;
          fill      = 8'd0;
          sum       = 8'd0;
          phase     = xmcs_pkg::PH_WAIT_GO;
        end
      end else if (phase == xmcs_pkg::PH_IN_BLOCK && mode == xmcs_pkg::MODE_EOF) begin
        pad_and_close();
      end else if (phase == xmcs_pkg::PH_WAIT_REPLY && mode == xmcs_pkg::MODE_RX) begin
        push(8'd0, 8'd0, (b == xmcs_pkg::SYM_ACK) ? xmcs_pkg::ST_DONE_ACK :
                                                    xmcs_pkg::ST_DONE_NAK);
        restart();
      end else begin
        push(8'd0, 8'd0, xmcs_pkg::ST_DROP);
      end
      tx_expected[tx_expected.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(logic [23:0] d, logic l);
      tx_result_t e;
      if (tx_expected.size() == 0) begin
        $display("%0t: result with nothing expected: tdata %h last %b", $time, d, l);
        errors++;
        return;
      end
      e = tx_expected.pop_front();
      if (d[7:0] !== e.tx_byte) begin
        $display("%0t: tx_byte expected %h actual %h", $time, e.tx_byte, d[7:0]);
        errors++;
      end
      if (d[15:8] !== e.reps) begin
        $display("%0t: repeat expected %0d actual %0d", $time, e.reps, d[15:8]);
        errors++;
      end
      if (d[17:16] !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, d[17:16]);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] byte_in
  logic [1:0]  s_axis_tuser = 2'd0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [7:0] tx_byte, [15:8] repeat_res, [17:16] status
  logic        m_axis_tlast;

  frame_scoreboard sb;
  int cycles = 0;
  int items_sent = 0;
  bit tx_burst = 1'b0;

  xmodem_checksum_block_sender uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high across back-to-back transfers
  task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(mode, b);
    items_sent++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 24) == 0)
      send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // go byte, payload with go bytes at block boundaries, end of file, reply
  task automatic send_file();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(0, 20);
    else if (pick < 8) len = $urandom_range(120, 135);
    else if (pick == 8) len = ($urandom_range(0, 1) == 0) ? 128 : 256;
    else len = 0;
    // keep the total close to the planned item count
    if (items_sent + len > ITEM_COUNT + 20) len = ITEM_COUNT - items_sent;
    tx_burst = ($urandom_range(0, 3) == 0);
    send_item(xmcs_pkg::MODE_RX,
              ($urandom_range(0, 1) == 0) ? xmcs_pkg::SYM_ACK : 8'($urandom_range(0, 255)));
    for (int i = 0; i < len; i++) begin
      maybe_noise();
      send_item(xmcs_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
      if ((i + 1) % xmcs_pkg::BLOCK_BYTES == 0 && i + 1 < len)
        send_item(xmcs_pkg::MODE_RX, xmcs_pkg::SYM_ACK);
    end
    maybe_noise();
    send_item(xmcs_pkg::MODE_EOF, 8'($urandom_range(0, 255)));
    // file ended on a block boundary: the next go byte sends the padding block
    if (len > 0 && len % xmcs_pkg::BLOCK_BYTES == 0)
      send_item(xmcs_pkg::MODE_RX, xmcs_pkg::SYM_ACK);
    send_item(xmcs_pkg::MODE_RX,
              ($urandom_range(0, 1) == 0) ? xmcs_pkg::SYM_ACK : 8'($urandom_range(0, 255)));
  endtask

  initial begin : rx_side
    int  stall;
    int  taken;
    bit  no_stall;
    taken    = 0;
    no_stall = 1'b0;
    wait (rst_ni);
    forever begin
      if (taken % 40 == 0) no_stall = ($urandom_range(0, 2) == 0);
      // long hold-off so the input side backs up
      if (taken == 30 || taken == 300) stall = 250;
      else stall = no_stall ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_byte(m_axis_tdata, m_axis_tlast);
      taken++;
    end
  end

  initial begin : tx_side
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // end of file between blocks, then the drops after it
    send_item(xmcs_pkg::MODE_EOF, 8'h00);
    send_item(xmcs_pkg::MODE_EOF, 8'hFF);
    send_item(xmcs_pkg::MODE_DATA, 8'hFF);
    send_item(2'd3, 8'h5A);
    // go byte after pending end of file: header plus a full padding block
    send_item(xmcs_pkg::MODE_RX, 8'h15);
    send_item(xmcs_pkg::MODE_DATA, 8'h11);
    send_item(xmcs_pkg::MODE_EOF, 8'h00);
    send_item(2'd3, 8'h00);
    send_item(xmcs_pkg::MODE_RX, xmcs_pkg::SYM_ACK);
    // short file with drops in the middle of a block
    send_item(xmcs_pkg::MODE_RX, 8'h00);
    send_item(xmcs_pkg::MODE_DATA, 8'h00);
    send_item(xmcs_pkg::MODE_DATA, 8'hFF);
    send_item(xmcs_pkg::MODE_RX, xmcs_pkg::SYM_ACK);
    send_item(2'd3, 8'hFF);
    send_item(xmcs_pkg::MODE_EOF, 8'hA5);
    send_item(xmcs_pkg::MODE_RX, 8'hFF);
    send_item(xmcs_pkg::MODE_RX, 8'hAA);
    send_item(xmcs_pkg::MODE_DATA, 8'h55);
    send_item(xmcs_pkg::MODE_EOF, 8'h00);
    send_item(xmcs_pkg::MODE_RX, xmcs_pkg::SYM_ACK);

    while (items_sent < ITEM_COUNT) send_file();

    s_axis_tvalid <= 1'b0;
    while (sb.tx_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
